// ===== design/imd_pkg.sv =====
// ---------------------------------------------------------------------------
// imd_pkg: shared types and constants of the interrupt mask dispatcher
// Request and response payloads, command and status codes, and the
// controller/datapath handshake structs.
// ---------------------------------------------------------------------------
`default_nettype none

package imd_pkg;

   // Default line counts, handed to the top level parameters
   localparam int DEF_SHARED_LINES = 64;
   localparam int DEF_LOCAL_LINES  = 8;

   // Lines per group word and groups in the block
   localparam int GROUP_BITS = 32;
   localparam int NUM_GROUPS = 3;
   localparam int BIT_W      = $clog2(GROUP_BITS);
   localparam int IRQ_W      = 7;

   // Command codes
   typedef enum logic [1:0] {
      CMD_ENABLE   = 2'd0,
      CMD_DISABLE  = 2'd1,
      CMD_HANDLER  = 2'd2,
      CMD_DISPATCH = 2'd3
   } command_type;

   // Group codes
   localparam logic [1:0] GRP_LOW   = 2'd0;
   localparam logic [1:0] GRP_HIGH  = 2'd1;
   localparam logic [1:0] GRP_LOCAL = 2'd2;

   // Status codes
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_INVALID = 2'd1;
   localparam logic [1:0] STS_HALTED  = 2'd2;

   typedef struct packed {
      command_type             command;
      logic [IRQ_W-1:0]        irq_number;
      logic                    handler_present;
      logic [1:0]              group;
      logic [GROUP_BITS-1:0]   pending_word;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             serve_valid;
      logic [IRQ_W-1:0] irq_to_serve;
      logic             no_handler;
      logic             last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load_single;   // take request, one response
      logic load_walk;     // take dispatch request, start walk
      logic step;          // emit next walk response
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic single_item;   // request gives exactly one response
      logic walk_end;      // current walk step is the final one
      logic out_free;      // output register can take a response
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/imd_controller.sv =====
// ---------------------------------------------------------------------------
// imd_controller: sequencing of the interrupt mask dispatcher
// Takes one request at a time and steps a dispatch walk one response per
// cycle while the output register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module imd_controller
   import imd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  dp_status_type      dp_status,
   output ctl_cmd_type        ctl_cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Command decode and next state
   always_comb begin
      ctl_cmd   = '0;
      state_in  = state_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !dp_status.out_free;
            if (req_valid && dp_status.out_free) begin
               if (dp_status.single_item) begin
                  ctl_cmd.load_single = 1'b1;
               end else begin
                  ctl_cmd.load_walk = 1'b1;
                  state_in          = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (dp_status.out_free) begin
               ctl_cmd.step = 1'b1;
               if (dp_status.walk_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/imd_datapath.sv =====
// ---------------------------------------------------------------------------
// imd_datapath: masks, handler bits and dispatch walk of the dispatcher
// Holds the enable words, handler-present bits, halted flag, the sampled due
// word of a walk and the response output register.
// ---------------------------------------------------------------------------
`default_nettype none

module imd_datapath
   import imd_pkg::*;
#(
   parameter int SHARED_LINES = DEF_SHARED_LINES,
   parameter int LOCAL_LINES  = DEF_LOCAL_LINES
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  req_type            req_payload,
   input  ctl_cmd_type        ctl_cmd,
   output dp_status_type      dp_status,
   input  wire logic          rsp_stall,
   output logic               rsp_valid,
   output rsp_type            rsp_payload
);

   localparam int TOTAL_LINES = SHARED_LINES + LOCAL_LINES;
   localparam int IDX_W       = $clog2(TOTAL_LINES);
   localparam logic [IRQ_W-1:0] TOTAL_NUM  = IRQ_W'(TOTAL_LINES);
   localparam logic [IRQ_W-1:0] SHARED_NUM = IRQ_W'(SHARED_LINES);
   localparam logic [IRQ_W-1:0] GROUP_NUM  = IRQ_W'(GROUP_BITS);
   localparam logic [63:0] ONE64 = 64'd1;
   localparam logic [GROUP_BITS-1:0] HIGH_MASK =
      GROUP_BITS'((ONE64 << (SHARED_LINES - GROUP_BITS)) - ONE64);
   localparam logic [GROUP_BITS-1:0] LOCAL_MASK =
      GROUP_BITS'((ONE64 << LOCAL_LINES) - ONE64);

   // Highest set bit of a group word
   function automatic logic [BIT_W-1:0] top_bit(input logic [GROUP_BITS-1:0] v);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int b = 0; b < GROUP_BITS; b++) begin
         if (v[b]) begin
            idx = BIT_W'(b);
         end
      end
      return idx;
   endfunction

   logic [GROUP_BITS-1:0] enable_ff [NUM_GROUPS];
   logic [GROUP_BITS-1:0] enable_in [NUM_GROUPS];
   logic [TOTAL_LINES-1:0] handler_ff, handler_in;
   logic                  halted_ff, halted_in;
   logic [GROUP_BITS-1:0] due_ff, due_in;
   logic [IRQ_W-1:0]      base_ff, base_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_payload_ff, rsp_payload_in;

   logic [IRQ_W-1:0]      line;
   logic                  line_ok;
   logic [IRQ_W-1:0]      line_off_high, line_off_local;
   logic [1:0]            sel_grp;
   logic [BIT_W-1:0]      sel_bit;
   logic [GROUP_BITS-1:0] due_init;
   logic                  group_ok;
   logic [BIT_W-1:0]      walk_bit;
   logic [GROUP_BITS-1:0] due_rest;
   logic [IRQ_W-1:0]      walk_line;
   logic                  handler_hit;
   logic                  step_fault;
   logic                  out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Line number to group and bit
   always_comb begin
      line           = req_payload.irq_number;
      line_ok        = line < TOTAL_NUM;
      line_off_high  = line - GROUP_NUM;
      line_off_local = line - SHARED_NUM;
      if (line < GROUP_NUM) begin
         sel_grp = GRP_LOW;
         sel_bit = line[BIT_W-1:0];
      end else if (line < SHARED_NUM) begin
         sel_grp = GRP_HIGH;
         sel_bit = line_off_high[BIT_W-1:0];
      end else begin
         sel_grp = GRP_LOCAL;
         sel_bit = line_off_local[BIT_W-1:0];
      end
   end

   // Due word of a dispatch, sampled once from the request
   always_comb begin
      group_ok = 1'b1;
      unique case (req_payload.group)
         GRP_LOW:   due_init = enable_ff[0] & req_payload.pending_word;
         GRP_HIGH:  due_init = enable_ff[1] & req_payload.pending_word & HIGH_MASK;
         GRP_LOCAL: due_init = enable_ff[2] & req_payload.pending_word & LOCAL_MASK;
         default: begin
            due_init = '0;
            group_ok = 1'b0;
         end
      endcase
   end

   // Walk step: highest due line and its handler
   always_comb begin
      walk_bit    = top_bit(due_ff);
      due_rest    = due_ff & ~(GROUP_BITS'(1) << walk_bit);
      walk_line   = base_ff + IRQ_W'(walk_bit);
      handler_hit = (walk_line < TOTAL_NUM) && handler_ff[walk_line[IDX_W-1:0]];
      step_fault  = !handler_hit;
   end

   assign dp_status.single_item = halted_ff || (req_payload.command != CMD_DISPATCH) ||
                                  !group_ok || (due_init == '0);
   assign dp_status.walk_end    = step_fault || (due_rest == '0);
   assign dp_status.out_free    = out_free;

   // Next state of all registers
   always_comb begin
      enable_in      = enable_ff;
      handler_in     = handler_ff;
      halted_in      = halted_ff;
      due_in         = due_ff;
      base_in        = base_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;

      if (ctl_cmd.load_single) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = '0;
         rsp_payload_in.last = 1'b1;
         if (halted_ff) begin
            rsp_payload_in.status = STS_HALTED;
         end else if (req_payload.command != CMD_DISPATCH) begin
            if (!line_ok) begin
               rsp_payload_in.status = STS_INVALID;
            end else begin
               rsp_payload_in.status = STS_OK;
               unique case (req_payload.command)
                  CMD_ENABLE:  enable_in[sel_grp][sel_bit] = 1'b1;
                  CMD_DISABLE: enable_in[sel_grp][sel_bit] = 1'b0;
                  CMD_HANDLER: handler_in[line[IDX_W-1:0]] = req_payload.handler_present;
                  default: ;
               endcase
            end
         end else if (!group_ok) begin
            rsp_payload_in.status = STS_INVALID;
         end else begin
            rsp_payload_in.status = STS_OK;
         end
      end

      if (ctl_cmd.load_walk) begin
         due_in = due_init;
         unique case (req_payload.group)
            GRP_HIGH:  base_in = GROUP_NUM;
            GRP_LOCAL: base_in = SHARED_NUM;
            default:   base_in = '0;
         endcase
      end

      if (ctl_cmd.step) begin
         due_in                      = due_rest;
         rsp_valid_in                = 1'b1;
         rsp_payload_in.status       = STS_OK;
         rsp_payload_in.irq_to_serve = walk_line;
         rsp_payload_in.serve_valid  = handler_hit;
         rsp_payload_in.no_handler   = step_fault;
         rsp_payload_in.last         = step_fault || (due_rest == '0);
         if (step_fault) begin
            halted_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            enable_ff[g] <= '0;
         end
         handler_ff   <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         handler_ff   <= handler_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      due_ff         <= due_in;
      base_ff        <= base_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Checks
   a_step_not_halted: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.step |-> !halted_ff)
      else $error("walk step while halted");

   a_load_needs_free: assert property (@(posedge clock) disable iff (reset)
      (ctl_cmd.load_single || ctl_cmd.load_walk || ctl_cmd.step) |-> out_free)
      else $error("response register overwritten");

   a_fault_halts: assert property (@(posedge clock) disable iff (reset)
      (ctl_cmd.step && step_fault) |=> halted_ff)
      else $error("fault did not halt");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted cleared without reset");

endmodule

`default_nettype wire

// ===== design/interrupt_mask_dispatcher.sv =====
// ---------------------------------------------------------------------------
// interrupt_mask_dispatcher: interrupt line masking and dispatch
// Commands enable or disable lines and register handlers; a dispatch request
// walks one group's due lines from the highest bit down.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one request per handshake (valid high, stall low). Enable,
//            disable and handler requests each give one response.
//   rsp_*  : responses leave a single output register. A dispatch gives one
//            response per due line, highest first, up to any fault, last set on the final one;
//            an empty dispatch gives one response.
//   Timing: a single response appears in the cycle after its request is taken;
//            the first response of a dispatch walk passes the due word register, then the output register.
//   Requests: one request at a time; a new request is not taken until the
//            walk of a dispatch ends. The walk steps one line per cycle
//            while the output register is free.
//   A missing handler gives a fault response and halts the block; every
//   later request gets a halted status until reset.
//   Reset clears all enables, all handler bits and the halted flag.
//   While rsp_stall is high and a response is valid, it holds, the walk pauses and
//   req_stall is raised.
// ---------------------------------------------------------------------------
`default_nettype none

module interrupt_mask_dispatcher
   import imd_pkg::*;
#(
   parameter int SHARED_LINES = DEF_SHARED_LINES,
   parameter int LOCAL_LINES  = DEF_LOCAL_LINES
)(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  req_type   req_payload,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type   rsp_payload
);

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   imd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .ctl_cmd   (ctl_cmd)
   );

   imd_datapath #(
      .SHARED_LINES (SHARED_LINES),
      .LOCAL_LINES  (LOCAL_LINES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctl_cmd     (ctl_cmd),
      .dp_status   (dp_status),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
